// ----- rtl/core/light_sensor_autorange_lux_unit_assert.svh -----
// Assertion macros for the light sensor auto-range lux unit.
`ifndef LIGHT_SENSOR_AUTORANGE_LUX_UNIT_ASSERT_SVH
`define LIGHT_SENSOR_AUTORANGE_LUX_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LSAL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lux unit assertion failed");

// Next-cycle implication, disabled during reset.
`define LSAL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lux unit assertion failed");

`endif

// ----- rtl/core/lsal_pkg.sv -----
// Shared types, constants and helper functions of the lux unit.
`timescale 1ns / 1ps
package lsal_pkg;

  localparam int unsigned RawW      = 16;
  localparam int unsigned BaseW     = 24;
  localparam int unsigned ThrW      = 16;
  localparam int unsigned LuxW      = 49;
  localparam int unsigned ProdW     = RawW + BaseW;
  localparam int unsigned GainW     = 2;
  localparam int unsigned IntegW    = 3;
  localparam int unsigned ActW      = 3;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned ShiftW    = 4;

  localparam logic [GainW-1:0]  GainTop  = 2'd3;
  localparam logic [IntegW-1:0] IntegTop = 3'd5;

  localparam logic [ThrW-1:0]  LowThrReset  = 16'd6553;
  localparam logic [ThrW-1:0]  HighThrReset = 16'd58981;
  localparam logic [BaseW-1:0] LuxBaseReset = 24'd60398;

  localparam int unsigned QueueDepthDefault = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_THR    = 3'd0,
    CFG_HIGH_THR   = 3'd1,
    CFG_LUX_BASE   = 3'd2,
    CFG_AUTO_EN    = 3'd3,
    CFG_START_GAIN = 3'd4,
    CFG_START_INT  = 3'd5
  } cfg_reg_e;

  typedef enum logic [ActW-1:0] {
    ACT_NONE   = 3'd0,
    ACT_RESET  = 3'd1,
    ACT_GAIN   = 3'd2,
    ACT_INTEG  = 3'd3,
    ACT_AT_MAX = 3'd4
  } range_action_e;

  // One classified reading on its way from front to back.
  typedef struct packed {
    logic [RawW-1:0]   raw;
    logic [GainW-1:0]  gain;
    logic [IntegW-1:0] integ;
    logic [GainW-1:0]  next_gain;
    logic [IntegW-1:0] next_integ;
    range_action_e     action;
  } lsal_item_t;

  // Combined left shift for gain x16/x8/x2/x1 and integration x32..x1.
  function automatic logic [ShiftW-1:0] scale_shift(input logic [GainW-1:0] g,
                                                    input logic [IntegW-1:0] t);
    logic [ShiftW-1:0] gs;
    logic [ShiftW-1:0] ts;
    case (g)
      2'd0:    gs = 4'd4;
      2'd1:    gs = 4'd3;
      2'd2:    gs = 4'd1;
      default: gs = 4'd0;
    endcase
    case (t)
      3'd0:    ts = 4'd5;
      3'd1:    ts = 4'd4;
      3'd2:    ts = 4'd3;
      3'd3:    ts = 4'd2;
      3'd4:    ts = 4'd1;
      default: ts = 4'd0;
    endcase
    return gs + ts;
  endfunction

endpackage

// ----- rtl/core/lsal_front.sv -----
// Front end: configuration registers, ranging state and item classification.
`timescale 1ns / 1ps
module lsal_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsal_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsal_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lsal_pkg::RawW-1:0]     raw_count_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output lsal_pkg::lsal_item_t          item_o,
  output logic [lsal_pkg::BaseW-1:0]    lux_base_o
);
  import lsal_pkg::*;

  logic [ThrW-1:0]   low_thr_q;
  logic [ThrW-1:0]   high_thr_q;
  logic [BaseW-1:0]  lux_base_q;
  logic              auto_en_q;
  logic [GainW-1:0]  gain_q,  gain_d;
  logic [IntegW-1:0] integ_q, integ_d;
  range_action_e     action_d;
  logic              accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept;
  assign lux_base_o = lux_base_q;

  // Ranging decision for the current reading; reset to minimum wins.
  always_comb begin
    gain_d   = gain_q;
    integ_d  = integ_q;
    action_d = ACT_NONE;
    if (auto_en_q) begin
      if (raw_count_i >= high_thr_q) begin
        gain_d   = '0;
        integ_d  = '0;
        action_d = ACT_RESET;
      end else if (raw_count_i <= low_thr_q) begin
        if (gain_q != GainTop) begin
          gain_d   = gain_q + 2'd1;
          action_d = ACT_GAIN;
        end else if (integ_q != IntegTop) begin
          integ_d  = integ_q + 3'd1;
          gain_d   = '0;
          action_d = ACT_INTEG;
        end else begin
          action_d = ACT_AT_MAX;
        end
      end
    end
  end

  always_comb begin
    item_o.raw        = raw_count_i;
    item_o.gain       = gain_q;
    item_o.integ      = integ_q;
    item_o.next_gain  = gain_d;
    item_o.next_integ = integ_d;
    item_o.action     = action_d;
  end

  // Config writes and step updates; the user must write only while idle, the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_thr_q  <= LowThrReset;
      high_thr_q <= HighThrReset;
      lux_base_q <= LuxBaseReset;
      auto_en_q  <= 1'b1;
      gain_q     <= '0;
      integ_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOW_THR:    low_thr_q  <= cfg_data_i[ThrW-1:0];
        CFG_HIGH_THR:   high_thr_q <= cfg_data_i[ThrW-1:0];
        CFG_LUX_BASE:   lux_base_q <= cfg_data_i[BaseW-1:0];
        CFG_AUTO_EN:    auto_en_q  <= cfg_data_i[0];
        CFG_START_GAIN: gain_q     <= cfg_data_i[GainW-1:0];
        // out-of-range integration steps saturate to the top step
        CFG_START_INT:  integ_q    <= (cfg_data_i[IntegW-1:0] > IntegTop) ?
                                      IntegTop : cfg_data_i[IntegW-1:0];
        default: ;
      endcase
    end else if (accept) begin
      gain_q  <= gain_d;
      integ_q <= integ_d;
    end
  end

endmodule

// ----- rtl/core/lsal_queue.sv -----
// Short item queue between the ranging front end and the scaling back end.
`timescale 1ns / 1ps
module lsal_queue #(
  parameter int unsigned Depth = lsal_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  lsal_pkg::lsal_item_t item_i,
  output logic                 full_o,
  output logic                 valid_o,
  input  logic                 pop_i,
  output lsal_pkg::lsal_item_t item_o
);
  import lsal_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  lsal_item_t      slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = slots_q[rd_ptr_q];

  // Item storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ----- rtl/core/lsal_back.sv -----
// Back end: lux scaling multiply and the output register.
`timescale 1ns / 1ps
module lsal_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  output logic                                q_pop_o,
  input  lsal_pkg::lsal_item_t                q_item_i,
  input  logic [lsal_pkg::BaseW-1:0]          lux_base_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lsal_pkg::LuxW-1:0]           lux_value_o,
  output logic [lsal_pkg::GainW-1:0]          gain_used_o,
  output logic [lsal_pkg::IntegW-1:0]         integration_used_o,
  output logic [lsal_pkg::GainW-1:0]          next_gain_o,
  output logic [lsal_pkg::IntegW-1:0]         next_integration_o,
  output logic [lsal_pkg::ActW-1:0]           range_action_o
);
  import lsal_pkg::*;

  logic              out_valid_q;
  logic [LuxW-1:0]   lux_q, lux_d;
  logic [ProdW-1:0]  prod;
  logic [ShiftW-1:0] shamt;
  lsal_item_t        item_q;
  logic              load;

  // Output register is free when empty or being taken this cycle
  assign load    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = load;

  // 16x24 product, then the combined power-of-two scale
  assign prod  = ProdW'(q_item_i.raw) * ProdW'(lux_base_i);
  assign shamt = scale_shift(q_item_i.gain, q_item_i.integ);
  assign lux_d = LuxW'(prod) << shamt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      lux_q  <= lux_d;
      item_q <= q_item_i;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign lux_value_o        = lux_q;
  assign gain_used_o        = item_q.gain;
  assign integration_used_o = item_q.integ;
  assign next_gain_o        = item_q.next_gain;
  assign next_integration_o = item_q.next_integ;
  assign range_action_o     = item_q.action;

endmodule

// ----- rtl/core/light_sensor_autorange_lux_unit.sv -----
// Top level of the light sensor auto-range lux unit.
//
// Takes one 16-bit raw light count per item and returns one result per item:
// the lux value (unsigned, 24 fraction bits) from raw_count * lux_base scaled
// by the gain and integration steps in force, plus the steps used, the steps
// after the auto-ranging decision and the ranging action. Sustained rate is
// one item per clock while neither side stalls; an accepted item is written
// into the queue and then into the output register, where its result is held
// while the output side is stalled. The rate is set by the per-item update of
// the gain/integration state in the front end and the
// single 16x24 multiply stage in the back end; a small queue (QueueDepth
// items) between them absorbs output stalls. Configuration writes take
// effect at once and are expected only while no item is in flight.
`timescale 1ns / 1ps
module light_sensor_autorange_lux_unit #(
  parameter int unsigned QueueDepth = lsal_pkg::QueueDepthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsal_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lsal_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lsal_pkg::RawW-1:0]     raw_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lsal_pkg::LuxW-1:0]     lux_value_o,
  output logic [lsal_pkg::GainW-1:0]    gain_used_o,
  output logic [lsal_pkg::IntegW-1:0]   integration_used_o,
  output logic [lsal_pkg::GainW-1:0]    next_gain_o,
  output logic [lsal_pkg::IntegW-1:0]   next_integration_o,
  output logic [lsal_pkg::ActW-1:0]     range_action_o
);
  import lsal_pkg::*;

  logic             q_full, q_valid, q_pop, push;
  lsal_item_t       push_item, pop_item;
  logic [BaseW-1:0] lux_base;

  lsal_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .raw_count_i (raw_count_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item),
    .lux_base_o  (lux_base)
  );

  lsal_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (pop_item)
  );

  lsal_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_pop_o            (q_pop),
    .q_item_i           (pop_item),
    .lux_base_i         (lux_base),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .lux_value_o        (lux_value_o),
    .gain_used_o        (gain_used_o),
    .integration_used_o (integration_used_o),
    .next_gain_o        (next_gain_o),
    .next_integration_o (next_integration_o),
    .range_action_o     (range_action_o)
  );

endmodule

// ----- rtl/core/lsal_checker.sv -----
// Port-level assertion checker for the lux unit, bound to the top level.
`timescale 1ns / 1ps
`include "light_sensor_autorange_lux_unit_assert.svh"
module lsal_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [lsal_pkg::LuxW-1:0]     lux_value_o,
  input logic [lsal_pkg::GainW-1:0]    gain_used_o,
  input logic [lsal_pkg::IntegW-1:0]   integration_used_o,
  input logic [lsal_pkg::GainW-1:0]    next_gain_o,
  input logic [lsal_pkg::IntegW-1:0]   next_integration_o,
  input logic [lsal_pkg::ActW-1:0]     range_action_o
);
  import lsal_pkg::*;

  // A stalled result holds
  `LSAL_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(lux_value_o) && $stable(next_gain_o))

  // Integration steps never leave their range
  `LSAL_ASSERT_NOW(a_integ_range, out_valid_o, integration_used_o <= IntegTop && next_integration_o <= IntegTop)

  // Reset to minimum clears both steps
  `LSAL_ASSERT_NOW(a_reset_min, out_valid_o && range_action_o == ACT_RESET, next_gain_o == '0 && next_integration_o == '0)

  // Gain raise steps gain by one and keeps integration
  `LSAL_ASSERT_NOW(a_gain_up, out_valid_o && range_action_o == ACT_GAIN, next_gain_o == gain_used_o + 2'd1 && next_integration_o == integration_used_o)

  // Integration raise drops gain to minimum and steps integration by one
  `LSAL_ASSERT_NOW(a_integ_up, out_valid_o && range_action_o == ACT_INTEG, next_gain_o == '0 && gain_used_o == GainTop && next_integration_o == integration_used_o + 3'd1)

endmodule

bind light_sensor_autorange_lux_unit lsal_checker u_lsal_checker (.*);
